@@ rtl/mmar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmar_pkg: shared constants and helpers for the mesh route computation
// Port codes, register indexes, LFSR seed and small bit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mmar_pkg;

  // Field widths
  localparam int unsigned IdW    = 8;
  localparam int unsigned ColsW  = 9;
  localparam int unsigned PortW  = 4;
  localparam int unsigned VcW    = 3;
  localparam int unsigned CntW   = 4;
  localparam int unsigned BusyW  = 8;
  localparam int unsigned NipW   = 2;
  localparam int unsigned LfsrW  = 16;
  localparam int unsigned CostW  = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 9;

  // Output port codes
  localparam logic [PortW-1:0] PortNorth = 4'd0;
  localparam logic [PortW-1:0] PortEast  = 4'd1;
  localparam logic [PortW-1:0] PortSouth = 4'd2;
  localparam logic [PortW-1:0] PortWest  = 4'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegRouterId  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMeshCols  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRouteMode = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNumIntPts = 3'd3;
  localparam logic [CfgIdxW-1:0] RegNumVcs    = 3'd4;

  // Reset values
  localparam logic [LfsrW-1:0] LfsrSeed     = 16'hACE1;
  localparam logic [ColsW-1:0] ColsReset    = 9'd8;
  localparam logic [CntW-1:0]  IntPtsReset  = 4'd4;
  localparam logic [CntW-1:0]  NumVcsReset  = 4'd4;
  localparam logic [CntW-1:0]  MaxCountVcs  = 4'd8;

  // One Fibonacci step, taps 16,14,13,11, shifting right
  function automatic logic [LfsrW-1:0] lfsr_step(input logic [LfsrW-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LfsrW-1:1]};
  endfunction

  // Count of busy VCs among the lowest lim bits
  function automatic logic [CntW-1:0] busy_count(input logic [BusyW-1:0] mask,
                                                 input logic [CntW-1:0]  lim);
    logic [CntW-1:0] n;
    n = '0;
    for (int i = 0; i < BusyW; i++) begin
      if ((CntW'(i) < lim) && mask[i]) begin
        n = n + 4'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mesh_min_adaptive_route.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_min_adaptive_route: route computation for one 2D mesh router
// Splits router ids into mesh coordinates with a shared bit-serial divider,
// then picks the minimal output port (op 0) or checks VC class rules (op 1).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one request beat: op,
//   source and destination ids, busy masks of the four mesh outputs and the
//   ports/VCs for the class check. Output channel (out_valid_o /
//   out_ready_i) returns one beat per request: route_port and vc_allowed.
//   Config channel (cfg_valid_i / cfg_ready_o) is always ready and writes
//   one register per beat; write it only while no request is in flight.
//   One restoring divider stage retires one quotient bit per cycle and is
//   run twice per request (two ids of 8 bits each), then a decide step
//   loads the output register. The block takes no new request until that
//   load is done. If the receiver stalls, the finished result holds in the
//   output register and the block waits in its decide step until the
//   output register is free.
//   Reset loads the register defaults (8 columns, 4 mesh ports, 4 VCs,
//   adaptive mode) and the LFSR seed; no clearing pass is needed.
`default_nettype none

module mesh_min_adaptive_route (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [mmar_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [mmar_pkg::CfgDatW-1:0]  cfg_data_i,
  // request channel
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          op_i,
  input  wire logic [mmar_pkg::IdW-1:0]      src_router_i,
  input  wire logic [mmar_pkg::IdW-1:0]      dest_router_i,
  input  wire logic [mmar_pkg::NipW-1:0]     ni_out_pos_i,
  input  wire logic [mmar_pkg::BusyW-1:0]    east_busy_i,
  input  wire logic [mmar_pkg::BusyW-1:0]    west_busy_i,
  input  wire logic [mmar_pkg::BusyW-1:0]    north_busy_i,
  input  wire logic [mmar_pkg::BusyW-1:0]    south_busy_i,
  input  wire logic [mmar_pkg::PortW-1:0]    in_port_i,
  input  wire logic [mmar_pkg::VcW-1:0]      in_vc_i,
  input  wire logic [mmar_pkg::VcW-1:0]      out_vc_i,
  input  wire logic [mmar_pkg::PortW-1:0]    out_port_i,
  // result channel
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [mmar_pkg::PortW-1:0]    route_port_o,
  output      logic                          vc_allowed_o
);
  import mmar_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  // configuration registers
  logic [IdW-1:0]   router_id_q;
  logic [ColsW-1:0] mesh_cols_q;
  logic             routing_mode_q;
  logic [CntW-1:0]  num_int_ports_q;
  logic [CntW-1:0]  num_vcs_q;

  // control
  logic [1:0]       state_q, state_d;
  logic [2:0]       cnt_q;
  logic             sec_q;
  logic [LfsrW-1:0] lfsr_q;
  logic             out_valid_q;

  // latched request beat
  logic             op_q;
  logic [IdW-1:0]   dest_q;
  logic [NipW-1:0]  nip_q;
  logic [BusyW-1:0] eb_q, wb_q, nb_q, sb_q;
  logic [PortW-1:0] in_port_q, out_port_q;
  logic [VcW-1:0]   in_vc_q, out_vc_q;

  // divider datapath and first-pass results
  logic [IdW-1:0]   dq_q, dq_d;
  logic [IdW-1:0]   rem_q, rem_d;
  logic [IdW-1:0]   x0_q, y0_q;
  logic [ColsW-1:0] cols_eff;
  logic [ColsW-1:0] trial;
  logic             ge;

  // result registers
  logic [PortW-1:0] route_port_q;
  logic             vc_allowed_q;

  logic             in_fire, cfg_fire, load_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;
  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_out    = (state_q == StDone) && (!out_valid_q || out_ready_i);

  assign out_valid_o  = out_valid_q;
  assign route_port_o = route_port_q;
  assign vc_allowed_o = vc_allowed_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      router_id_q     <= '0;
      mesh_cols_q     <= ColsReset;
      routing_mode_q  <= 1'b0;
      num_int_ports_q <= IntPtsReset;
      num_vcs_q       <= NumVcsReset;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        RegRouterId:  router_id_q     <= cfg_data_i[IdW-1:0];
        RegMeshCols:  mesh_cols_q     <= cfg_data_i;
        RegRouteMode: routing_mode_q  <= cfg_data_i[0];
        RegNumIntPts: num_int_ports_q <= cfg_data_i[CntW-1:0];
        RegNumVcs:    num_vcs_q       <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  // Restoring divider step: one quotient bit per cycle
  assign cols_eff = (mesh_cols_q == '0) ? ColsW'(1) : mesh_cols_q;
  assign trial    = {rem_q, dq_q[IdW-1]};
  assign ge       = (trial >= cols_eff);
  assign rem_d    = ge ? IdW'(trial - cols_eff) : trial[IdW-1:0];
  assign dq_d     = {dq_q[IdW-2:0], ge};

  // Route decision, evaluated in the decide step
  logic [IdW-1:0]   dx, dy, cx, cy;
  logic [PortW-1:0] port_sel;
  logic             vc_ok;
  logic             both_prod;
  logic [LfsrW-1:0] lfsr_x, lfsr_y;
  logic [CntW-1:0]  lim;
  logic [CostW-1:0] cost_x, cost_y;
  logic [PortW-1:0] xport, yport;
  logic [BusyW-1:0] xbusy, ybusy;
  logic [VcW-1:0]   half;
  logic             ovc_lo, ivc_lo;

  always_comb begin
    dx = x0_q;
    dy = y0_q;
    cx = rem_q;
    cy = dq_q;
    lim    = (num_vcs_q > MaxCountVcs) ? MaxCountVcs : num_vcs_q;
    lfsr_x = lfsr_step(lfsr_q);
    lfsr_y = lfsr_step(lfsr_x);
    xport  = (dx > cx) ? PortEast : PortWest;
    xbusy  = (dx > cx) ? eb_q : wb_q;
    yport  = (dy > cy) ? PortSouth : PortNorth;
    ybusy  = (dy > cy) ? sb_q : nb_q;
    both_prod = (dx != cx) && (dy != cy);
    if (routing_mode_q) begin
      cost_x = lfsr_x[CostW-1:0];
      cost_y = lfsr_y[CostW-1:0];
    end else begin
      cost_x = CostW'(busy_count(xbusy, lim));
      cost_y = CostW'(busy_count(ybusy, lim));
    end
    // port selection
    if (dx == cx) begin
      if (dy == cy) begin
        port_sel = num_int_ports_q + PortW'(nip_q);
      end else begin
        port_sel = yport;
      end
    end else if (dy == cy) begin
      port_sel = xport;
    end else begin
      port_sel = (cost_x < cost_y) ? xport : yport;
    end
    // VC class check: y0 is the source row, dq the destination row
    half   = num_vcs_q[CntW-1:1];
    ovc_lo = (out_vc_q < half);
    ivc_lo = (in_vc_q < half);
    if (out_port_q >= num_int_ports_q) begin
      vc_ok = 1'b1;
    end else if (dq_q == y0_q) begin
      vc_ok = (in_port_q >= num_int_ports_q) ? 1'b1 : (ivc_lo == ovc_lo);
    end else if (!(out_port_q == PortEast || out_port_q == PortWest)) begin
      vc_ok = 1'b1;
    end else if (dq_q > y0_q) begin
      vc_ok = !ovc_lo;
    end else begin
      vc_ok = ovc_lo;
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_fire) state_d = StDiv;
      StDiv:  if ((cnt_q == 3'd7) && sec_q) state_d = StDone;
      StDone: if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      sec_q       <= 1'b0;
      lfsr_q      <= LfsrSeed;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDiv) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          sec_q <= !sec_q;
        end
      end
      if (load_out && !op_q && routing_mode_q && both_prod) begin
        lfsr_q <= lfsr_y;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q       <= op_i;
      dest_q     <= dest_router_i;
      nip_q      <= ni_out_pos_i;
      eb_q       <= east_busy_i;
      wb_q       <= west_busy_i;
      nb_q       <= north_busy_i;
      sb_q       <= south_busy_i;
      in_port_q  <= in_port_i;
      in_vc_q    <= in_vc_i;
      out_vc_q   <= out_vc_i;
      out_port_q <= out_port_i;
      // first division: destination for routing, source for the VC check
      dq_q       <= op_i ? src_router_i : dest_router_i;
      rem_q      <= '0;
    end else if (state_q == StDiv) begin
      if ((cnt_q == 3'd7) && !sec_q) begin
        x0_q  <= rem_d;
        y0_q  <= dq_d;
        dq_q  <= op_q ? dest_q : router_id_q;
        rem_q <= '0;
      end else begin
        dq_q  <= dq_d;
        rem_q <= rem_d;
      end
    end
    if (load_out) begin
      route_port_q <= op_q ? '0 : port_sel;
      vc_allowed_q <= op_q ? vc_ok : 1'b0;
    end
  end

  // Assertions
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StDiv && cnt_q == 3'd0 && !sec_q))
    else $error("request beat did not start the divider");

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("LFSR reached the all-zero lockup state");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == StDone))
    else $error("result beat raised outside the decide step");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && vc_allowed_q) |-> (route_port_q == PortNorth))
    else $error("VC check result carries a route port");

  a_idle_counter_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (cnt_q == 3'd0 && !sec_q))
    else $error("divider sequencer not cleared when idle");

endmodule

`default_nettype wire
